// File: rtl/melody_sequencer_triangle_tone_core_defines.svh
// Assertion macros for the melody sequencer tone core.
`ifndef MELODY_SEQUENCER_TRIANGLE_TONE_CORE_DEFINES_SVH
`define MELODY_SEQUENCER_TRIANGLE_TONE_CORE_DEFINES_SVH
`ifndef SYNTH
`define MSTT_ASSERT_RST(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define MSTT_ASSERT_CLK(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define MSTT_ASSERT_RST(label, clk, rstn, prop)
`define MSTT_ASSERT_CLK(label, clk, prop)
`endif
`endif

// File: rtl/mstt_pkg.sv
`default_nettype none
package mstt_pkg;

    localparam int STEP_W   = 24;
    localparam int LEN_W    = 4;
    localparam int TIME_W   = 32;
    localparam int INDEX_W  = 7;
    localparam int OP_W     = 2;
    localparam int MLEN_W   = 8;
    localparam int BEAT_W   = 24;
    localparam int GAP_W    = 2;
    localparam int AMP_W    = 7;
    localparam int SAMPLE_W = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    typedef logic [OP_W-1:0]      op_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam op_t OP_SAMPLE = 2'd0;
    localparam op_t OP_UPDATE = 2'd1;
    localparam op_t OP_WRITE  = 2'd2;

    localparam cfg_idx_t CFG_MELODY_LENGTH = 2'd0;
    localparam cfg_idx_t CFG_BEAT_UNIT     = 2'd1;
    localparam cfg_idx_t CFG_GAP_UPDATES   = 2'd2;
    localparam cfg_idx_t CFG_AMPLITUDE     = 2'd3;

    localparam logic [MLEN_W-1:0] MLEN_RESET = 8'd128;
    localparam logic [BEAT_W-1:0] BEAT_RESET = 24'd1;
    localparam logic [GAP_W-1:0]  GAP_RESET  = 2'd2;
    localparam logic [AMP_W-1:0]  AMP_RESET  = 7'd32;

endpackage
`default_nettype wire

// File: rtl/melody_sequencer_triangle_tone_core.sv
`default_nettype none
// Melody sequencer with triangle tone output. Takes one item per clock unless
// the input stage holds: sample requests (operation 0) return one signed
// triangle sample via the input register and then the output register; time
// updates (1) and table writes (2) return nothing. Items pass through a single
// input register stage; it holds only when a sample request meets a full output
// register that is not being taken. The melody table's two memories have registered
// reads issued at accept time, so no clearing pass runs after reset; entries must
// be written before they are played. Configuration must be written through
// cfg_we/cfg_index/cfg_wdata while no item is in flight; the block does not enforce it.
`include "melody_sequencer_triangle_tone_core_defines.svh"
module melody_sequencer_triangle_tone_core
    import mstt_pkg::*;
#(
    parameter int TABLE_DEPTH = 128,
    parameter int PHASE_BITS  = 24
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_we,
    input  wire logic [CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [CFG_DATA_W-1:0]      cfg_wdata,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [OP_W-1:0]            s_operation,
    input  wire logic [TIME_W-1:0]          s_time_now,
    input  wire logic [INDEX_W-1:0]         s_entry_index,
    input  wire logic [STEP_W-1:0]          s_entry_step,
    input  wire logic [LEN_W-1:0]           s_entry_length,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic signed [SAMPLE_W-1:0]      m_sample
);

    localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CMP_W = (AW + 1 > MLEN_W) ? AW + 1 : MLEN_W;
    localparam int EW    = (AW > INDEX_W) ? AW : INDEX_W;
    localparam int PB    = PHASE_BITS;
    localparam logic [PB:0] PHASE_ONE = {1'b1, {PB{1'b0}}};

    typedef logic [AW-1:0] addr_t;

    function automatic addr_t wrap_next(input addr_t p, input logic [MLEN_W-1:0] ml);
        logic [CMP_W-1:0] n;
        n = CMP_W'(p) + CMP_W'(1);
        if (n >= CMP_W'(ml) || n >= CMP_W'(TABLE_DEPTH)) begin
            return '0;
        end
        return AW'(n);
    endfunction

    // configuration
    logic [MLEN_W-1:0] mlen_reg;
    logic [BEAT_W-1:0] beat_reg;
    logic [GAP_W-1:0]  gap_cfg_reg;
    logic [AMP_W-1:0]  amp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mlen_reg    <= MLEN_RESET;
            beat_reg    <= BEAT_RESET;
            gap_cfg_reg <= GAP_RESET;
            amp_reg     <= AMP_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_MELODY_LENGTH: mlen_reg    <= cfg_wdata[MLEN_W-1:0];
                CFG_BEAT_UNIT:     beat_reg    <= cfg_wdata[BEAT_W-1:0];
                CFG_GAP_UPDATES:   gap_cfg_reg <= cfg_wdata[GAP_W-1:0];
                CFG_AMPLITUDE:     amp_reg     <= cfg_wdata[AMP_W-1:0];
                default: ;
            endcase
        end
    end

    // input stage
    logic              in_valid_reg;
    op_t               in_op_reg;
    logic [TIME_W-1:0] in_time_reg;
    logic              m_valid_reg;
    logic signed [SAMPLE_W-1:0] m_sample_reg;
    logic              fire;
    logic              accept;

    assign fire    = in_valid_reg && (in_op_reg != OP_SAMPLE || !m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            in_op_reg   <= s_operation;
            in_time_reg <= s_time_now;
        end
    end

    // sequencer state
    addr_t              pos_reg, pos_next;
    logic [GAP_W-1:0]   gap_cnt_reg, gap_cnt_next;
    logic [TIME_W-1:0]  deadline_reg, deadline_next;
    logic [PB-1:0]      phase_reg, phase_next;
    logic [STEP_W-1:0]  cur_step_reg, cur_step_next;

    // melody table: write at accept; at accept read steps at current and next positions, lengths at the next two
    logic [STEP_W-1:0] step_mem [TABLE_DEPTH];
    logic [LEN_W-1:0]  len_mem  [TABLE_DEPTH];
    logic [STEP_W-1:0] step_rd_a_reg, step_rd_b_reg;
    logic [LEN_W-1:0]  len_rd_a_reg, len_rd_b_reg;
    addr_t             rd_base_reg;
    addr_t             rd_n1, rd_n2;
    logic              wr_en;
    addr_t             wr_addr;

    assign rd_n1   = wrap_next(pos_reg, mlen_reg);
    assign rd_n2   = wrap_next(rd_n1, mlen_reg);
    assign wr_addr = AW'(s_entry_index);
    assign wr_en   = accept && s_operation == OP_WRITE
                     && {1'b0, EW'(s_entry_index)} < (EW + 1)'(TABLE_DEPTH);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            step_mem[wr_addr] <= s_entry_step;
            len_mem[wr_addr]  <= s_entry_length;
        end
        if (accept) begin
            step_rd_a_reg <= step_mem[pos_reg];
            step_rd_b_reg <= step_mem[rd_n1];
            len_rd_a_reg  <= len_mem[rd_n1];
            len_rd_b_reg  <= len_mem[rd_n2];
            rd_base_reg   <= pos_reg;
        end
    end

    // pick the entries for the position as it stands now
    logic              moved;
    logic [STEP_W-1:0] entry_step;
    logic [LEN_W-1:0]  next_len;
    logic [BEAT_W+LEN_W-1:0] beat_prod;
    logic [PB+STEP_W-1:0]    step_wide;

    assign moved      = pos_reg != rd_base_reg;
    assign entry_step = moved ? step_rd_b_reg : step_rd_a_reg;
    assign next_len   = moved ? len_rd_b_reg : len_rd_a_reg;
    assign beat_prod  = (BEAT_W + LEN_W)'(beat_reg) * (BEAT_W + LEN_W)'(next_len);
    assign step_wide  = {cur_step_reg, {PB{1'b0}}};

    // triangle
    logic [1:0]    quad;
    logic [PB-1:0] ramp;
    logic [PB:0]   mag;
    logic          neg;
    logic [PB+7:0] scaled;
    logic [SAMPLE_W-1:0] mag8;
    logic signed [SAMPLE_W-1:0] sample_val;

    always_comb begin
        quad = phase_reg[PB-1:PB-2];
        ramp = {phase_reg[PB-3:0], 2'b00};
        neg  = quad[1];
        if (quad[0]) begin
            mag = PHASE_ONE - {1'b0, ramp};
        end else begin
            mag = {1'b0, ramp};
        end
        scaled = (PB + 8)'(amp_reg) * (PB + 8)'(mag);
        mag8   = scaled[PB +: SAMPLE_W];
        if (cur_step_reg == '0) begin
            sample_val = '0;
        end else if (neg) begin
            sample_val = -$signed(mag8);
        end else begin
            sample_val = $signed(mag8);
        end
    end

    always_comb begin
        pos_next      = pos_reg;
        gap_cnt_next  = gap_cnt_reg;
        deadline_next = deadline_reg;
        phase_next    = phase_reg;
        cur_step_next = cur_step_reg;
        if (fire) begin
            case (in_op_reg)
                OP_SAMPLE: begin
                    if (cur_step_reg != '0) begin
                        phase_next = phase_reg + step_wide[STEP_W +: PB];
                    end
                end
                OP_UPDATE: begin
                    if (gap_cnt_reg < gap_cfg_reg) begin
                        cur_step_next = '0;
                        gap_cnt_next  = gap_cnt_reg + GAP_W'(1);
                    end else begin
                        cur_step_next = entry_step;
                        if (in_time_reg > deadline_reg) begin
                            gap_cnt_next  = '0;
                            pos_next      = wrap_next(pos_reg, mlen_reg);
                            deadline_next = deadline_reg + TIME_W'(beat_prod);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            gap_cnt_reg  <= '0;
            deadline_reg <= '0;
            phase_reg    <= '0;
            cur_step_reg <= '0;
        end else begin
            pos_reg      <= pos_next;
            gap_cnt_reg  <= gap_cnt_next;
            deadline_reg <= deadline_next;
            phase_reg    <= phase_next;
            cur_step_reg <= cur_step_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fire && in_op_reg == OP_SAMPLE) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && in_op_reg == OP_SAMPLE) begin
            m_sample_reg <= sample_val;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_sample = m_sample_reg;

    `MSTT_ASSERT_RST(a_pos_step, aclk, aresetn, pos_reg != $past(pos_reg) |-> pos_reg == '0 || pos_reg == $past(pos_reg) + AW'(1))
    `MSTT_ASSERT_RST(a_silent_zero, aclk, aresetn, fire && in_op_reg == OP_SAMPLE && cur_step_reg == '0 |=> m_sample_reg == '0)
    `MSTT_ASSERT_RST(a_phase_hold, aclk, aresetn, !(fire && in_op_reg == OP_SAMPLE) |=> $stable(phase_reg))
    `MSTT_ASSERT_RST(a_deadline_gap, aclk, aresetn, deadline_reg != $past(deadline_reg) |-> gap_cnt_reg == '0)
    `MSTT_ASSERT_CLK(a_reset_idle, aclk, !aresetn |=> !m_valid_reg && !in_valid_reg)

endmodule
`default_nettype wire

// File: tb/melody_sequencer_triangle_tone_core_tb.sv
module melody_sequencer_triangle_tone_core_tb;
    import mstt_pkg::*;

    localparam op_t OP_IGNORED     = 2'd3;
    localparam int  TABLE_SIZE     = 128;
    localparam int  STALL_LIMIT    = 5000;
    localparam int  PHASE_COUNT    = 6;
    localparam int  ITEMS_PER_PHASE = 300;
    localparam int  HOLD_OFF_CYCLES = 80;

    class tone_scoreboard;
        logic [STEP_W-1:0]          step_mem [TABLE_SIZE];
        logic [LEN_W-1:0]           len_mem [TABLE_SIZE];
        logic [INDEX_W-1:0]         note_pos;
        logic [GAP_W-1:0]           gap_cnt;
        logic [TIME_W-1:0]          deadline;
        logic [23:0]                phase_acc;
        logic [STEP_W-1:0]          cur_step;
        logic [MLEN_W-1:0]          melody_len;
        logic [BEAT_W-1:0]          beat_ticks;
        logic [GAP_W-1:0]           gap_len;
        logic [AMP_W-1:0]           amp;
        logic signed [SAMPLE_W-1:0] expected_samples [$];
        int                         errors;

        function new();
            foreach (step_mem[i]) begin
                step_mem[i] = '0;
                len_mem[i]  = '0;
            end
            note_pos   = '0;
            gap_cnt    = '0;
            deadline   = '0;
            phase_acc  = '0;
            cur_step   = '0;
            melody_len = MLEN_RESET;
            beat_ticks = BEAT_RESET;
            gap_len    = GAP_RESET;
            amp        = AMP_RESET;
            errors     = 0;
        endfunction

        function void set_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_MELODY_LENGTH: melody_len = value[MLEN_W-1:0];
                CFG_BEAT_UNIT:     beat_ticks = value[BEAT_W-1:0];
                CFG_GAP_UPDATES:   gap_len    = value[GAP_W-1:0];
                CFG_AMPLITUDE:     amp        = value[AMP_W-1:0];
                default: ;
            endcase
        endfunction

        function logic signed [SAMPLE_W-1:0] triangle_value();
            bit [63:0]         one;
            bit [63:0]         t;
            bit [63:0]         mag;
            bit                neg;
            logic [SAMPLE_W-1:0] m8;
            one = 64'd1 << 24;
            t   = {40'd0, phase_acc} * 64'd4;
            if (t < one) begin
                mag = t;
                neg = 1'b0;
            end else if (t <= 2 * one) begin
                mag = 2 * one - t;
                neg = 1'b0;
            end else if (t < 3 * one) begin
                mag = t - 2 * one;
                neg = 1'b1;
            end else begin
                mag = 4 * one - t;
                neg = 1'b1;
            end
            mag = (64'(amp) * mag) >> 24;
            m8  = mag[SAMPLE_W-1:0];
            return neg ? (8'd0 - m8) : m8;
        endfunction

        function void next_note();
            logic [8:0] p;
            p = {2'b00, note_pos} + 9'd1;
            if (p >= {1'b0, melody_len} || p >= TABLE_SIZE)
                p = '0;
            note_pos = p[INDEX_W-1:0];
        endfunction

        function void note_item(op_t op, logic [TIME_W-1:0] now, logic [INDEX_W-1:0] idx,
                                logic [STEP_W-1:0] step, logic [LEN_W-1:0] len);
            case (op)
                OP_SAMPLE: begin
                    if (cur_step == 0) begin
                        expected_samples.push_back('0);
                    end else begin
                        expected_samples.push_back(triangle_value());
                        phase_acc = phase_acc + cur_step;
                    end
                end
                OP_UPDATE: begin
                    if (gap_cnt < gap_len) begin
                        cur_step = '0;
                        gap_cnt  = gap_cnt + 2'd1;
                    end else begin
                        cur_step = step_mem[note_pos];
                        if (now > deadline) begin
                            gap_cnt = '0;
                            next_note();
                            deadline = deadline + 32'(beat_ticks) * 32'(len_mem[note_pos]);
                        end
                    end
                end
                OP_WRITE: begin
                    step_mem[idx] = step;
                    len_mem[idx]  = len;
                end
                default: ;
            endcase
        endfunction

        function void check_sample(logic signed [SAMPLE_W-1:0] got);
            logic signed [SAMPLE_W-1:0] want;
            if (expected_samples.size() == 0) begin
                $display("%0t: unexpected sample: expected none, actual %0d", $time, got);
                errors++;
                return;
            end
            want = expected_samples.pop_front();
            if (got !== want) begin
                $display("%0t: sample mismatch: expected %0d, actual %0d", $time, want, got);
                errors++;
            end
        endfunction
    endclass

    logic                       aclk           = 1'b0;
    logic                       aresetn        = 1'b0;
    logic                       cfg_we         = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index      = '0;
    logic [CFG_DATA_W-1:0]      cfg_wdata      = '0;
    logic                       s_valid        = 1'b0;
    wire                        s_ready;
    logic [OP_W-1:0]            s_operation    = '0;
    logic [TIME_W-1:0]          s_time_now     = '0;
    logic [INDEX_W-1:0]         s_entry_index  = '0;
    logic [STEP_W-1:0]          s_entry_step   = '0;
    logic [LEN_W-1:0]           s_entry_length = '0;
    wire                        m_valid;
    logic                       m_ready        = 1'b0;
    wire signed [SAMPLE_W-1:0]  m_sample;

    tone_scoreboard sb = new();

    int                 send_idle_pct = 0;
    int                 recv_idle_pct = 0;
    bit                 hold_request  = 1'b0;
    logic [TIME_W-1:0]  clock_ticks   = '0;

    melody_sequencer_triangle_tone_core u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_time_now     (s_time_now),
        .s_entry_index  (s_entry_index),
        .s_entry_step   (s_entry_step),
        .s_entry_length (s_entry_length),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sample       (m_sample)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_sample(m_sample);
    end

    initial begin
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("melody_sequencer_triangle_tone_core test failed");
        $finish;
    end

    task automatic send_item(op_t op, logic [TIME_W-1:0] now, logic [INDEX_W-1:0] idx,
                             logic [STEP_W-1:0] step, logic [LEN_W-1:0] len);
        if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_operation    <= op;
        s_time_now     <= now;
        s_entry_index  <= idx;
        s_entry_step   <= step;
        s_entry_length <= len;
        do @(posedge aclk); while (!s_ready);
        sb.note_item(op, now, idx, step, len);
    endtask

    // drop valid and wait for every pending sample, then let the pipeline empty
    task automatic settle(int extra);
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.expected_samples.size() != 0);
        repeat (extra) @(posedge aclk);
    endtask

    task automatic write_config(logic [MLEN_W-1:0] mel, logic [BEAT_W-1:0] beat,
                                logic [GAP_W-1:0] gap, logic [AMP_W-1:0] level);
        cfg_idx_t              regs [4];
        logic [CFG_DATA_W-1:0] vals [4];
        regs = '{CFG_MELODY_LENGTH, CFG_BEAT_UNIT, CFG_GAP_UPDATES, CFG_AMPLITUDE};
        vals = '{CFG_DATA_W'(mel), beat, CFG_DATA_W'(gap), CFG_DATA_W'(level)};
        for (int k = 0; k < 4; k++) begin
            cfg_we    <= 1'b1;
            cfg_index <= regs[k];
            cfg_wdata <= vals[k];
            @(posedge aclk);
            sb.set_register(regs[k], vals[k]);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic send_random_item();
        int                 r;
        op_t                op;
        logic [TIME_W-1:0]  now;
        logic [INDEX_W-1:0] idx;
        logic [STEP_W-1:0]  step;
        logic [LEN_W-1:0]   len;
        r    = $urandom_range(0, 99);
        now  = $urandom;
        idx  = $urandom;
        step = $urandom;
        len  = $urandom;
        if (r < 55) begin
            op = OP_SAMPLE;
        end else if (r < 80) begin
            op = OP_UPDATE;
            if ($urandom_range(0, 39) != 0) begin
                clock_ticks = clock_ticks + $urandom_range(0, 8 * int'(sb.beat_ticks));
                now = clock_ticks;
            end
        end else if (r < 95) begin
            op = OP_WRITE;
            if ($urandom_range(0, 7) == 0)
                step = '0;
        end else begin
            op = OP_IGNORED;
        end
        send_item(op, now, idx, step, len);
    endtask

    initial begin
        logic [MLEN_W-1:0] mel_set  [PHASE_COUNT];
        logic [BEAT_W-1:0] beat_set [PHASE_COUNT];
        logic [GAP_W-1:0]  gap_set  [PHASE_COUNT];
        logic [AMP_W-1:0]  amp_set  [PHASE_COUNT];

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_item(OP_SAMPLE, '0, '0, '0, '0);
        send_item(OP_IGNORED, '1, '1, '1, '1);
        for (int i = 0; i < TABLE_SIZE; i++) begin
            case (i)
                0:       send_item(OP_WRITE, $urandom, 7'(i), '1, '1);
                1:       send_item(OP_WRITE, $urandom, 7'(i), '0, '0);
                2:       send_item(OP_WRITE, $urandom, 7'(i), 24'd1, 4'd15);
                default: send_item(OP_WRITE, $urandom, 7'(i), $urandom, $urandom);
            endcase
        end
        repeat (3) send_item(OP_UPDATE, '0, '0, '0, '0);
        repeat (4) send_item(OP_SAMPLE, '0, '0, '0, '0);
        send_item(OP_UPDATE, '1, '0, '0, '0);
        repeat (2) send_item(OP_SAMPLE, '1, '1, '1, '1);
        repeat (3) send_item(OP_UPDATE, '1, '0, '0, '0);
        repeat (2) send_item(OP_SAMPLE, '0, '0, '0, '0);

        mel_set  = '{8'd128, 8'd0, 8'd1, 8'd255, 8'($urandom_range(2, 12)), 8'd128};
        beat_set = '{24'd1, 24'hFFFFFF, 24'd1, 24'($urandom_range(1, 64)),
                     24'($urandom_range(1, 24'hFFFFFF)), 24'hFFFFFF};
        gap_set  = '{2'd2, 2'd0, 2'd3, 2'd0, 2'd1, 2'd3};
        amp_set  = '{7'd32, 7'd127, 7'd0, 7'd127, 7'($urandom_range(1, 126)), 7'd1};

        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            settle(6);
            write_config(mel_set[ph], beat_set[ph], gap_set[ph], amp_set[ph]);
            send_idle_pct = (ph < 2) ? 29 : (ph < 4) ? 68 : 0;
            recv_idle_pct = (ph < 2) ? 68 : (ph < 4) ? 29 : 0;
            clock_ticks   = sb.deadline - $urandom_range(0, 4);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n == 100 && (ph == 1 || ph == 4))
                    hold_request = 1'b1;
                if (n == 150 && ph == 3)
                    settle(0);
                send_random_item();
            end
        end

        settle(10);
        if (sb.errors == 0 && sb.expected_samples.size() == 0) begin
            $display("melody_sequencer_triangle_tone_core test passed");
        end else begin
            $display("melody_sequencer_triangle_tone_core test failed");
        end
        $finish;
    end

endmodule
